>>> hdl/bsfd_pkg.sv
// ---------------------------------------------------------------------------
// bsfd_pkg
// Shared constants and types of the byte stuffed frame deframer.
// ---------------------------------------------------------------------------
package bsfd_pkg;

   localparam int FRAME_CAPACITY = 64;
   localparam int STORE_DEPTH    = 64;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int BYTE_W         = 8;
   localparam int LEN_W          = 7;

   localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7F;
   localparam logic [BYTE_W-1:0] ESC_DATA  = 8'h81;

   typedef enum logic [1:0] {
      PHASE_IDLE     = 2'd0,
      PHASE_ONE_FLAG = 2'd1,
      PHASE_IN_FRAME = 2'd2,
      PHASE_ESCAPE   = 2'd3
   } phase_type;

   // store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_type;

   // completed frame handed to the emitter
   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] length;
   } close_type;

endpackage

>>> hdl/bsfd_ram.sv
// ---------------------------------------------------------------------------
// bsfd_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module bsfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bsfd_rx.sv
// ---------------------------------------------------------------------------
// bsfd_rx
// Flag hunt and unstuffing; writes payload bytes into the frame store.
// ---------------------------------------------------------------------------
module bsfd_rx (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [bsfd_pkg::BYTE_W-1:0]  rx_byte,
   output bsfd_pkg::wr_type             wr,
   output bsfd_pkg::close_type          close
);

   bsfd_pkg::phase_type             phase_ff, phase_in;
   logic [bsfd_pkg::LEN_W-1:0]      count_ff, count_in;
   logic [bsfd_pkg::LEN_W-1:0]      count_inc;
   logic                            is_flag;

   assign count_inc = count_ff + bsfd_pkg::LEN_W'(1);
   assign is_flag   = (rx_byte == bsfd_pkg::FLAG_BYTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bsfd_pkg::PHASE_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      wr.en        = 1'b0;
      wr.addr      = count_ff[bsfd_pkg::ADDR_W-1:0];
      wr.data      = rx_byte;
      close.start  = 1'b0;
      close.length = count_ff;
      if (accept) begin
         unique case (phase_ff)
            bsfd_pkg::PHASE_IDLE: begin
               if (is_flag) begin
                  phase_in = bsfd_pkg::PHASE_ONE_FLAG;
               end
            end
            bsfd_pkg::PHASE_ONE_FLAG: begin
               if (is_flag) begin
                  phase_in = bsfd_pkg::PHASE_IN_FRAME;
                  count_in = '0;
               end else begin
                  phase_in = bsfd_pkg::PHASE_IDLE;
               end
            end
            bsfd_pkg::PHASE_IN_FRAME: begin
               if (is_flag) begin
                  phase_in = bsfd_pkg::PHASE_ESCAPE;
               end else begin
                  wr.en = 1'b1;
               end
            end
            bsfd_pkg::PHASE_ESCAPE: begin
               if (rx_byte == bsfd_pkg::ESC_DATA) begin
                  wr.en   = 1'b1;
                  wr.data = bsfd_pkg::FLAG_BYTE;
               end else if (is_flag) begin
                  if (count_ff == '0) begin
                     // empty close acts as a repeated opening flag
                     phase_in = bsfd_pkg::PHASE_IN_FRAME;
                  end else begin
                     close.start = 1'b1;
                     phase_in    = bsfd_pkg::PHASE_IDLE;
                     count_in    = '0;
                  end
               end else begin
                  phase_in = bsfd_pkg::PHASE_IDLE;
                  count_in = '0;
               end
            end
            default: begin
               phase_in = bsfd_pkg::PHASE_IDLE;
            end
         endcase
         if (wr.en) begin
            // store full drops the frame
            if (count_inc >= bsfd_pkg::LEN_W'(bsfd_pkg::FRAME_CAPACITY)) begin
               phase_in = bsfd_pkg::PHASE_IDLE;
               count_in = '0;
            end else begin
               phase_in = bsfd_pkg::PHASE_IN_FRAME;
               count_in = count_inc;
            end
         end
      end
   end

endmodule

>>> hdl/bsfd_emit.sv
// ---------------------------------------------------------------------------
// bsfd_emit
// Reads a closed frame out of the store and drives the response register.
// ---------------------------------------------------------------------------
module bsfd_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  bsfd_pkg::close_type          close,
   output logic                         rd_en,
   output logic [bsfd_pkg::ADDR_W-1:0]  rd_addr,
   input  logic [bsfd_pkg::BYTE_W-1:0]  rd_data,
   output logic                         busy,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bsfd_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                         rsp_frame_end,
   output logic [bsfd_pkg::LEN_W-1:0]   rsp_frame_length
);

   logic                           active_ff, active_in;
   logic                           pend_ff, pend_in;
   logic                           pend_last_ff, pend_last_in;
   logic [bsfd_pkg::ADDR_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [bsfd_pkg::LEN_W-1:0]     len_ff, len_in;
   logic                           out_valid_ff, out_valid_in;
   logic [bsfd_pkg::BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                           out_end_ff, out_end_in;
   logic [bsfd_pkg::LEN_W-1:0]     out_len_ff, out_len_in;
   logic                           issue;
   logic                           is_last;

   // a read goes out only when the response register is free by the time data returns
   assign issue   = active_ff && !pend_ff && (!out_valid_ff || !rsp_stall);
   assign is_last = ({1'b0, rd_idx_ff} + bsfd_pkg::LEN_W'(1)) == len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      pend_last_ff <= pend_last_in;
      rd_idx_ff    <= rd_idx_in;
      len_ff       <= len_in;
      out_byte_ff  <= out_byte_in;
      out_end_ff   <= out_end_in;
      out_len_ff   <= out_len_in;
   end

   always_comb begin
      active_in    = active_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      rd_idx_in    = rd_idx_ff;
      len_in       = len_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_len_in   = out_len_ff;
      if (close.start) begin
         active_in = 1'b1;
         rd_idx_in = '0;
         len_in    = close.length;
      end else if (issue) begin
         pend_in      = 1'b1;
         pend_last_in = is_last;
         rd_idx_in    = rd_idx_ff + bsfd_pkg::ADDR_W'(1);
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (pend_ff) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data;
         out_end_in   = pend_last_ff;
         out_len_in   = len_ff;
      end
   end

   assign rd_en            = issue && !close.start;
   assign rd_addr          = rd_idx_ff;
   assign busy             = active_ff || pend_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_frame_end    = out_end_ff;
   assign rsp_frame_length = out_len_ff;

endmodule

>>> hdl/byte_stuffed_frame_deframer_unit.sv
// ---------------------------------------------------------------------------
// byte_stuffed_frame_deframer_unit
// Receives a byte stuffed link stream, stores each frame and replays the
// unstuffed payload of every completed frame, one byte per response.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_rx_byte
//   rsp      out  rsp_valid/rsp_stall  rsp_payload_byte, rsp_frame_end,
//                                      rsp_frame_length
//
// The store write happens at the accepting edge. A closed frame is replayed
// through one store read port with registered read data feeding a single
// response register; each read is issued only after the previous returned.
// req_stall is high from the cycle after the closing request until the last
// read returns.
// Reset (synchronous) clears phase, count and replay control; store contents
// stay undefined and are only read after being written in the same frame.
// rsp_stall holds the response register and pauses further store reads.
// ---------------------------------------------------------------------------
module byte_stuffed_frame_deframer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bsfd_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bsfd_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                         rsp_frame_end,
   output logic [bsfd_pkg::LEN_W-1:0]   rsp_frame_length
);

   bsfd_pkg::wr_type               wr;
   bsfd_pkg::close_type            close;
   logic                           busy;
   logic                           accept;
   logic                           rd_en;
   logic [bsfd_pkg::ADDR_W-1:0]    rd_addr;
   logic [bsfd_pkg::BYTE_W-1:0]    rd_data;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   bsfd_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .wr      (wr),
      .close   (close)
   );

   bsfd_ram #(
      .WIDTH (bsfd_pkg::BYTE_W),
      .DEPTH (bsfd_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bsfd_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .close            (close),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_length (rsp_frame_length)
   );

   // a new frame never closes while the previous one is still being read
   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      close.start |-> !busy)
      else $error("frame closed during replay");

   // store is never written while a replay reads it
   a_no_write_replay: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !busy)
      else $error("store write during replay");

   // a response always carries a real frame length
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_length != '0))
      else $error("response with zero frame length");

   // after a taken byte that is not the last, the replay continues
   a_replay_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_frame_end) |=> busy)
      else $error("replay stopped before frame end");

endmodule

>>> dv/byte_stuffed_frame_deframer_unit_check.sv
// ---------------------------------------------------------------------------
// byte_stuffed_frame_deframer_unit_check
// Watches both channels of the deframer. Every accepted link byte goes through
// a local model of the flag/escape receiver, and every closed frame queues
// its payload bytes. Each accepted response is compared field by field with
// the oldest queued byte. Hands back the mismatch count and the queue depth.
// ---------------------------------------------------------------------------
module byte_stuffed_frame_deframer_unit_check (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [bsfd_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [bsfd_pkg::BYTE_W-1:0] rsp_payload_byte,
   input  logic                        rsp_frame_end,
   input  logic [bsfd_pkg::LEN_W-1:0]  rsp_frame_length,
   output int                          mismatch_count,
   output int                          bytes_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [bsfd_pkg::BYTE_W-1:0] payload;
      logic                        last;
      logic [bsfd_pkg::LEN_W-1:0]  length;
   } frame_beat_type;

   bsfd_pkg::phase_type         link_phase;
   logic [bsfd_pkg::LEN_W-1:0]  held_count;
   logic [bsfd_pkg::BYTE_W-1:0] held_bytes [bsfd_pkg::STORE_DEPTH];
   frame_beat_type              beats_due [$];
   int                          errors;

   initial begin
      errors = 0;
      mismatch_count = 0;
      bytes_pending = 0;
      link_phase = bsfd_pkg::PHASE_IDLE;
      held_count = '0;
   end

   task automatic report(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic drop_frame();
      link_phase = bsfd_pkg::PHASE_IDLE;
      held_count = '0;
   endtask

   task automatic keep_byte(input logic [bsfd_pkg::BYTE_W-1:0] b);
      held_bytes[held_count[bsfd_pkg::ADDR_W-1:0]] = b;
      held_count = held_count + 1'b1;
      // a full store drops the frame
      if (held_count >= bsfd_pkg::FRAME_CAPACITY) begin
         drop_frame();
      end else begin
         link_phase = bsfd_pkg::PHASE_IN_FRAME;
      end
   endtask

   task automatic release_frame();
      frame_beat_type beat;
      for (int k = 0; k < held_count; k++) begin
         beat.payload = held_bytes[k];
         beat.last    = (k == held_count - 1);
         beat.length  = held_count;
         beats_due.push_back(beat);
      end
      drop_frame();
   endtask

   task automatic deframe_byte(input logic [bsfd_pkg::BYTE_W-1:0] b);
      case (link_phase)
         bsfd_pkg::PHASE_IDLE: begin
            if (b == bsfd_pkg::FLAG_BYTE) link_phase = bsfd_pkg::PHASE_ONE_FLAG;
         end
         bsfd_pkg::PHASE_ONE_FLAG: begin
            if (b == bsfd_pkg::FLAG_BYTE) begin
               link_phase = bsfd_pkg::PHASE_IN_FRAME;
               held_count = '0;
            end else begin
               link_phase = bsfd_pkg::PHASE_IDLE;
            end
         end
         bsfd_pkg::PHASE_IN_FRAME: begin
            if (b == bsfd_pkg::FLAG_BYTE) link_phase = bsfd_pkg::PHASE_ESCAPE;
            else keep_byte(b);
         end
         default: begin
            if (b == bsfd_pkg::ESC_DATA) begin
               keep_byte(bsfd_pkg::FLAG_BYTE);
            end else if (b == bsfd_pkg::FLAG_BYTE) begin
               // close on an empty store acts as another opening flag
               if (held_count == 0) link_phase = bsfd_pkg::PHASE_IN_FRAME;
               else release_frame();
            end else begin
               drop_frame();
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      frame_beat_type due;
      if (reset) begin
         link_phase = bsfd_pkg::PHASE_IDLE;
         held_count = '0;
         beats_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (beats_due.size() == 0) begin
               report($sformatf("response %h with no frame byte pending", rsp_payload_byte));
            end else begin
               due = beats_due.pop_front();
               if (rsp_payload_byte !== due.payload)
                  report($sformatf("payload_byte %h, expected %h",
                                   rsp_payload_byte, due.payload));
               if (rsp_frame_end !== due.last)
                  report($sformatf("frame_end %b, expected %b", rsp_frame_end, due.last));
               if (rsp_frame_length !== due.length)
                  report($sformatf("frame_length %0d, expected %0d",
                                   rsp_frame_length, due.length));
            end
         end
         if (req_valid && !req_stall) deframe_byte(req_rx_byte);
      end
      mismatch_count <= errors;
      bytes_pending  <= beats_due.size();
   end

endmodule

>>> dv/byte_stuffed_frame_deframer_unit_test.sv
// ---------------------------------------------------------------------------
// byte_stuffed_frame_deframer_unit_test
// Drives byte stuffed link traffic into the deframer: a directed opening on
// flags, escapes and dropped frames, then random frames of mixed length and
// noise, with random idle and stall outside frames 2-5; the checker judges.
// ---------------------------------------------------------------------------
module byte_stuffed_frame_deframer_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 140;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [bsfd_pkg::BYTE_W-1:0] req_rx_byte = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [bsfd_pkg::BYTE_W-1:0] rsp_payload_byte;
   logic                        rsp_frame_end;
   logic [bsfd_pkg::LEN_W-1:0]  rsp_frame_length;

   int mismatch_count;
   int bytes_pending;
   int idle_pct = 13;
   int stall_pct = 13;
   int sent_count = 0;
   int quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   byte_stuffed_frame_deframer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_length (rsp_frame_length)
   );

   byte_stuffed_frame_deframer_unit_check u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_length (rsp_frame_length),
      .mismatch_count   (mismatch_count),
      .bytes_pending    (bytes_pending)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [bsfd_pkg::BYTE_W-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_frames_out();
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
   endtask

   // random payload of n stored bytes, 0x7F stuffed as 0x7F 0x81
   task automatic send_payload(input int n);
      logic [bsfd_pkg::BYTE_W-1:0] b;
      for (int k = 0; k < n; k++) begin
         b = ($urandom_range(99) < 15) ? bsfd_pkg::FLAG_BYTE
                                       : bsfd_pkg::BYTE_W'($urandom_range(255));
         if (b == bsfd_pkg::FLAG_BYTE) begin
            send_byte(bsfd_pkg::FLAG_BYTE);
            send_byte(bsfd_pkg::ESC_DATA);
         end else begin
            send_byte(b);
         end
      end
   endtask

   task automatic send_frame(input int n, input bit closed);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::FLAG_BYTE);
      if ($urandom_range(99) < 10) begin
         send_byte(bsfd_pkg::FLAG_BYTE);
         send_byte(bsfd_pkg::FLAG_BYTE);
      end
      send_payload(n);
      if (closed) begin
         send_byte(bsfd_pkg::FLAG_BYTE);
         send_byte(bsfd_pkg::FLAG_BYTE);
      end
   endtask

   task automatic send_noise();
      logic [bsfd_pkg::BYTE_W-1:0] b;
      b = bsfd_pkg::BYTE_W'($urandom_range(255));
      if (b == bsfd_pkg::FLAG_BYTE || b == bsfd_pkg::ESC_DATA) b = 8'h00;
      case ($urandom_range(2))
         0: begin
            send_byte(b);
            send_byte(~b);
         end
         1: begin
            send_byte(bsfd_pkg::FLAG_BYTE);
            send_byte(b);
         end
         default: begin
            // frame broken by an unknown escape
            send_byte(bsfd_pkg::FLAG_BYTE);
            send_byte(bsfd_pkg::FLAG_BYTE);
            send_payload($urandom_range(1, 6));
            send_byte(bsfd_pkg::FLAG_BYTE);
            send_byte(b);
         end
      endcase
   endtask

   initial begin
      int frame_index;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // idle garbage, lone flag, open, empty close, escapes, close
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(8'h12);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::ESC_DATA);
      send_byte(bsfd_pkg::ESC_DATA);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::FLAG_BYTE);
      // bad escape drops the frame
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(8'h55);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(8'h33);
      // single byte frame
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(8'hAA);
      send_byte(bsfd_pkg::FLAG_BYTE);
      send_byte(bsfd_pkg::FLAG_BYTE);
      req_valid <= 1'b0;
      wait_frames_out();

      frame_index = 0;
      while (sent_count < 280 || frame_index <= 7) begin
         if (frame_index >= 2 && frame_index < 6) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = 13;
            stall_pct = 13;
         end
         if (frame_index == 4) begin
            send_frame(bsfd_pkg::FRAME_CAPACITY - 1, 1'b1);
         end else if (frame_index == 7) begin
            // store fills and the frame is dropped, no close needed
            send_frame(bsfd_pkg::FRAME_CAPACITY, 1'b0);
         end else if ($urandom_range(99) < 15) begin
            send_noise();
         end else begin
            n = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            send_frame(n, 1'b1);
         end
         if (frame_index == 5) begin
            req_valid <= 1'b0;
            wait_frames_out();
         end
         frame_index++;
      end
      req_valid <= 1'b0;

      wait_frames_out();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
